FILE: hw/rtl/edge_taper_mask_2d_assert.svh
// Assertion macros shared by the edge taper mask RTL.
// Needs no other file; users include it by its bare name.
`ifndef EDGE_TAPER_MASK_2D_ASSERT_SVH
`define EDGE_TAPER_MASK_2D_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ETM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ETM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ETM_ASSERT(label, clk, rst_n, prop, msg)
`define ETM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/etm_pkg.sv
// Package for the edge taper mask: widths, register map, types and the taper table.
// Used by every module of the block; depends on nothing.
package etm_pkg;

    localparam int MAX_AXIS      = 4096;
    localparam int SAMPLE_BITS   = 16;
    localparam int TABLE_ENTRIES = 1024;

    localparam int TBL_BITS     = $clog2(TABLE_ENTRIES);
    localparam int COORD_BITS   = $clog2(MAX_AXIS);
    localparam int REG_BITS     = COORD_BITS + 1;
    localparam int DIST_BITS    = REG_BITS + 1;
    localparam int WEIGHT_BITS  = 17;
    localparam int N_LANES      = 4;
    localparam int LANE_STAGES  = TBL_BITS + 2;
    localparam int MERGE_STAGES = 6;
    localparam int STAGES       = LANE_STAGES + MERGE_STAGES;
    localparam int ADDR_BITS    = 5;

    localparam logic [WEIGHT_BITS-1:0] ONE_Q16 = WEIGHT_BITS'(65536);
    localparam logic [REG_BITS-1:0]    REG_MAX = REG_BITS'(MAX_AXIS);

    typedef enum logic [2:0] {
        REG_AXIS1_SIZE = 3'd0,
        REG_AXIS2_SIZE = 3'd1,
        REG_AXIS1_LOW  = 3'd2,
        REG_AXIS1_HIGH = 3'd3,
        REG_AXIS2_LOW  = 3'd4,
        REG_AXIS2_HIGH = 3'd5,
        REG_TAPER_MODE = 3'd6,
        REG_ACCUMULATE = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        FAC_ONE   = 2'd0,
        FAC_ZERO  = 2'd1,
        FAC_TABLE = 2'd2
    } t_fac_kind;

    // One edge band as seen by a lane.
    typedef struct packed {
        logic                        active;
        logic signed [DIST_BITS-1:0] gap;
        logic signed [DIST_BITS-1:0] len;
    } t_band_req;

    // Sample data that travels beside the lanes.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] model_re;
        logic signed [SAMPLE_BITS-1:0] model_im;
        logic signed [SAMPLE_BITS-1:0] prior_re;
        logic signed [SAMPLE_BITS-1:0] prior_im;
        logic                          in_window;
    } t_side;

    typedef logic [N_LANES-1:0][WEIGHT_BITS-1:0] t_factors;
    typedef logic [WEIGHT_BITS-1:0] t_taper_table [TABLE_ENTRIES];

    localparam longint unsigned PI_Q30  = 64'hC90FDAA2;
    localparam longint          ONE_Q30 = 64'sd1 << 30;

    // Shift-and-subtract division, used only while the table is built.
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | longint'(num[b]);
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint cos_q30(longint unsigned t);
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        t2   = (t * t) >> 30;
        term = longint'(ONE_Q30);
        sum  = ONE_Q30;
        for (int n = 1; n <= 9; n++) begin
            term = udiv((term * t2) >> 30, 64'((2 * n - 1) * (2 * n)));
            if (n % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        if (sum > ONE_Q30) sum = ONE_Q30;
        if (sum < 0) sum = 0;
        return sum;
    endfunction

    // Entry k holds round(2^16 * (1 - cos(pi*k/N)) / 2), worked out at elaboration.
    function automatic t_taper_table build_table();
        t_taper_table    tbl;
        longint unsigned kk;
        longint unsigned t;
        longint          c;
        longint          w;
        logic            upper;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            upper = (2 * k > TABLE_ENTRIES);
            kk    = upper ? longint'(TABLE_ENTRIES - k) : longint'(k);
            t     = (PI_Q30 * kk) >> TBL_BITS;
            c     = cos_q30(t);
            if (upper) c = -c;
            w = (ONE_Q30 - c) >>> 1;
            if (w < 0) w = 0;
            if (w > ONE_Q30) w = ONE_Q30;
            tbl[k] = WEIGHT_BITS'((w + (64'sd1 << 13)) >>> 14);
        end
        return tbl;
    endfunction

    localparam t_taper_table TAPER_TABLE = build_table();

    function automatic logic [WEIGHT_BITS-1:0] apply_factor(
        logic [WEIGHT_BITS-1:0] w,
        logic [WEIGHT_BITS-1:0] f
    );
        logic [2*WEIGHT_BITS-1:0] p;
        p = (2*WEIGHT_BITS)'(w) * (2*WEIGHT_BITS)'(f) + (2*WEIGHT_BITS)'(32768);
        return p[WEIGHT_BITS+15:16];
    endfunction

endpackage

FILE: hw/rtl/etm_lane.sv
// One taper band lane: classify, pipelined restoring divide, registered table read.
// Depends on etm_pkg and the assertion macro header.
`include "edge_taper_mask_2d_assert.svh"
module etm_lane import etm_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [LANE_STAGES-1:0]       i_en,
    input  t_band_req                    i_req,
    output logic [WEIGHT_BITS-1:0]       o_factor
);

    t_fac_kind           r_kind [TBL_BITS+1];
    logic [REG_BITS-1:0] r_rem  [TBL_BITS+1];
    logic [REG_BITS-1:0] r_len  [TBL_BITS+1];
    logic [TBL_BITS-1:0] r_q    [TBL_BITS+1];
    logic [WEIGHT_BITS-1:0] r_factor;

    t_fac_kind n_kind;

    always_comb begin
        priority if (!i_req.active) begin
            n_kind = FAC_ONE;
        end else if (i_req.len <= 0 || i_req.gap <= 0) begin
            n_kind = FAC_ZERO;
        end else if (i_req.gap >= i_req.len) begin
            n_kind = FAC_ONE;
        end else begin
            n_kind = FAC_TABLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind[0] <= FAC_ONE;
        end else if (i_en[0]) begin
            r_kind[0] <= n_kind;
        end
        if (i_en[0]) begin
            r_rem[0] <= i_req.gap[REG_BITS-1:0];
            r_len[0] <= i_req.len[REG_BITS-1:0];
            r_q[0]   <= '0;
        end
    end

    // One quotient bit per stage; the remainder stays below the band length.
    for (genvar j = 1; j <= TBL_BITS; j++) begin : g_div
        logic [REG_BITS:0] w_shift;
        logic              w_ge;
        assign w_shift = {r_rem[j-1], 1'b0};
        assign w_ge    = (w_shift >= {1'b0, r_len[j-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_kind[j] <= FAC_ONE;
            end else if (i_en[j]) begin
                r_kind[j] <= r_kind[j-1];
            end
            if (i_en[j]) begin
                r_rem[j] <= w_ge ? REG_BITS'(w_shift - {1'b0, r_len[j-1]})
                                 : w_shift[REG_BITS-1:0];
                r_len[j] <= r_len[j-1];
                r_q[j]   <= {r_q[j-1][TBL_BITS-2:0], w_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[LANE_STAGES-1]) begin
            unique case (r_kind[TBL_BITS])
                FAC_TABLE: r_factor <= TAPER_TABLE[r_q[TBL_BITS]];
                FAC_ZERO:  r_factor <= '0;
                default:   r_factor <= ONE_Q16;
            endcase
        end
    end

    assign o_factor = r_factor;

    `ETM_ASSERT(a_rem_below_len, i_clk, i_rst_n, (r_kind[TBL_BITS] == FAC_TABLE) |-> (r_rem[TBL_BITS] < r_len[TBL_BITS]), "divider remainder reached band length")

endmodule

FILE: hw/rtl/etm_merge.sv
// Merge stage: folds the four band factors in taper mode, weights, may add, saturates.
// Depends on etm_pkg.
module etm_merge import etm_pkg::*; (
    input  logic                          i_clk,
    input  logic [MERGE_STAGES-1:0]       i_en,
    input  logic                          i_taper_mode,
    input  logic                          i_accumulate,
    input  t_factors                      i_factors,
    input  t_side                         i_side,
    output logic signed [SAMPLE_BITS-1:0] o_out_re,
    output logic signed [SAMPLE_BITS-1:0] o_out_im,
    output logic [WEIGHT_BITS-1:0]        o_weight,
    output logic                          o_saturated
);

    localparam int PROD_BITS = SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int RND_BITS  = PROD_BITS - 16;
    localparam int SUM_BITS  = RND_BITS + 1;

    logic [WEIGHT_BITS-1:0] r_w    [N_LANES+2];
    t_factors               r_fac  [N_LANES-1];
    t_side                  r_side [N_LANES+1];
    logic signed [PROD_BITS-1:0] r_prod_re, r_prod_im;
    logic signed [SAMPLE_BITS-1:0] r_out_re, r_out_im;
    logic                          r_sat;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_w[0]    <= i_taper_mode ? i_factors[0] : (i_side.in_window ? ONE_Q16 : '0);
            r_fac[0]  <= i_factors;
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 1; j < N_LANES; j++) begin : g_comb
        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_w[j]    <= i_taper_mode ? apply_factor(r_w[j-1], r_fac[j-1][j]) : r_w[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
        if (j < N_LANES - 1) begin : g_fac
            always_ff @(posedge i_clk) begin
                if (i_en[j]) r_fac[j] <= r_fac[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[N_LANES]) begin
            r_prod_re <= PROD_BITS'(r_side[N_LANES-1].model_re)
                         * $signed({1'b0, r_w[N_LANES-1]});
            r_prod_im <= PROD_BITS'(r_side[N_LANES-1].model_im)
                         * $signed({1'b0, r_w[N_LANES-1]});
            r_w[N_LANES]    <= r_w[N_LANES-1];
            r_side[N_LANES] <= r_side[N_LANES-1];
        end
    end

    logic signed [PROD_BITS-1:0] w_rnd_re, w_rnd_im;
    logic signed [SUM_BITS-1:0]  w_sum_re, w_sum_im;
    logic signed [SAMPLE_BITS-1:0] w_sat_re, w_sat_im;
    logic w_clip_re, w_clip_im;

    localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((1 << (SAMPLE_BITS-1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

    always_comb begin
        w_rnd_re = (r_prod_re + PROD_BITS'(32768)) >>> 16;
        w_rnd_im = (r_prod_im + PROD_BITS'(32768)) >>> 16;
        w_sum_re = $signed({w_rnd_re[RND_BITS-1], w_rnd_re[RND_BITS-1:0]});
        w_sum_im = $signed({w_rnd_im[RND_BITS-1], w_rnd_im[RND_BITS-1:0]});
        if (i_accumulate) begin
            w_sum_re = w_sum_re + SUM_BITS'(r_side[N_LANES].prior_re);
            w_sum_im = w_sum_im + SUM_BITS'(r_side[N_LANES].prior_im);
        end
        w_clip_re = (w_sum_re > SAT_HI) || (w_sum_re < SAT_LO);
        w_clip_im = (w_sum_im > SAT_HI) || (w_sum_im < SAT_LO);
        w_sat_re  = (w_sum_re > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                    (w_sum_re < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : w_sum_re[SAMPLE_BITS-1:0];
        w_sat_im  = (w_sum_im > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                    (w_sum_im < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : w_sum_im[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[N_LANES+1]) begin
            r_out_re       <= w_sat_re;
            r_out_im       <= w_sat_im;
            r_sat          <= w_clip_re || w_clip_im;
            r_w[N_LANES+1] <= r_w[N_LANES];
        end
    end

    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;
    assign o_weight    = r_w[N_LANES+1];
    assign o_saturated = r_sat;

endmodule

FILE: hw/rtl/edge_taper_mask_2d.sv
// Top level of the 2D edge taper mask: register port, stage control, lanes and merge.
// Depends on etm_pkg, etm_lane, etm_merge and the assertion macro header.
//
// The block weights one complex Q15 grid sample per word by a 2D window mask and
// optionally adds an earlier output value, saturating to Q15. It takes one word per
// cycle while the output is not stalled. Its stages, in order: classify each edge
// band, pipelined restoring division (one quotient bit per stage) that forms the
// 10-bit table index, the registered taper table read, folding the band factors
// into the weight, the sample multiply, and rounding, accumulation and saturation.
// Every stage has its own valid bit and moves whenever the stage after it is empty
// or moving, so a word that waits at the output does not stop new words from
// filling bubbles behind it. Four lanes (fast axis low and high edge, slow axis low
// and high edge) run side by side. The user must write registers over the APB port
// only while the block is idle; the block itself does not enforce this.
`include "edge_taper_mask_2d_assert.svh"
module edge_taper_mask_2d import etm_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [COORD_BITS-1:0]         i_column,
    input  logic [COORD_BITS-1:0]         i_row,
    input  logic signed [SAMPLE_BITS-1:0] i_model_re,
    input  logic signed [SAMPLE_BITS-1:0] i_model_im,
    input  logic signed [SAMPLE_BITS-1:0] i_prior_re,
    input  logic signed [SAMPLE_BITS-1:0] i_prior_im,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_re,
    output logic signed [SAMPLE_BITS-1:0] o_out_im,
    output logic [WEIGHT_BITS-1:0]        o_weight,
    output logic                          o_saturated
);

    // Configuration registers. Sizes and bounds clamp to the largest axis on write.
    logic [REG_BITS-1:0] r_axis1_size, r_axis2_size;
    logic [REG_BITS-1:0] r_axis1_low, r_axis1_high, r_axis2_low, r_axis2_high;
    logic                r_taper_mode, r_accumulate;

    t_reg_idx            w_idx;
    logic [REG_BITS-1:0] w_val;
    logic                w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign w_val  = (pwdata[REG_BITS-1:0] > REG_MAX) ? REG_MAX : pwdata[REG_BITS-1:0];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis1_size <= REG_MAX;
            r_axis2_size <= REG_MAX;
            r_axis1_low  <= '0;
            r_axis1_high <= REG_MAX;
            r_axis2_low  <= '0;
            r_axis2_high <= REG_MAX;
            r_taper_mode <= 1'b0;
            r_accumulate <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_AXIS1_SIZE: r_axis1_size <= w_val;
                REG_AXIS2_SIZE: r_axis2_size <= w_val;
                REG_AXIS1_LOW:  r_axis1_low  <= w_val;
                REG_AXIS1_HIGH: r_axis1_high <= w_val;
                REG_AXIS2_LOW:  r_axis2_low  <= w_val;
                REG_AXIS2_HIGH: r_axis2_high <= w_val;
                REG_TAPER_MODE: r_taper_mode <= pwdata[0];
                REG_ACCUMULATE: r_accumulate <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_AXIS1_SIZE: prdata = 32'(r_axis1_size);
            REG_AXIS2_SIZE: prdata = 32'(r_axis2_size);
            REG_AXIS1_LOW:  prdata = 32'(r_axis1_low);
            REG_AXIS1_HIGH: prdata = 32'(r_axis1_high);
            REG_AXIS2_LOW:  prdata = 32'(r_axis2_low);
            REG_AXIS2_HIGH: prdata = 32'(r_axis2_high);
            REG_TAPER_MODE: prdata = 32'(r_taper_mode);
            REG_ACCUMULATE: prdata = 32'(r_accumulate);
            default:        prdata = '0;
        endcase
    end

    // Stage control: each stage loads when it is empty or its word moves on.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_en;

    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[STAGES-1];

    // Band requests: low edges use the coordinate itself as distance, high edges
    // measure back from the grid size.
    logic [REG_BITS-1:0] w_col, w_row;
    t_band_req w_req [N_LANES];

    assign w_col = REG_BITS'(i_column);
    assign w_row = REG_BITS'(i_row);

    always_comb begin
        w_req[0].active = (w_col < r_axis1_low);
        w_req[0].gap    = DIST_BITS'(w_col);
        w_req[0].len    = DIST_BITS'(r_axis1_low);
        w_req[1].active = (w_col > r_axis1_high);
        w_req[1].gap    = DIST_BITS'(r_axis1_size) - DIST_BITS'(w_col);
        w_req[1].len    = DIST_BITS'(r_axis1_size) - DIST_BITS'(r_axis1_high);
        w_req[2].active = (w_row < r_axis2_low);
        w_req[2].gap    = DIST_BITS'(w_row);
        w_req[2].len    = DIST_BITS'(r_axis2_low);
        w_req[3].active = (w_row > r_axis2_high);
        w_req[3].gap    = DIST_BITS'(r_axis2_size) - DIST_BITS'(w_row);
        w_req[3].len    = DIST_BITS'(r_axis2_size) - DIST_BITS'(r_axis2_high);
    end

    t_factors w_factors;

    for (genvar l = 0; l < N_LANES; l++) begin : g_lane
        etm_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en[LANE_STAGES-1:0]),
            .i_req    (w_req[l]),
            .o_factor (w_factors[l])
        );
    end

    // Sample data rides alongside the lanes until the merge stage.
    t_side r_side [LANE_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0].model_re  <= i_model_re;
            r_side[0].model_im  <= i_model_im;
            r_side[0].prior_re  <= i_prior_re;
            r_side[0].prior_im  <= i_prior_im;
            r_side[0].in_window <= !(w_req[0].active || w_req[1].active ||
                                     w_req[2].active || w_req[3].active);
        end
        for (int k = 1; k < LANE_STAGES; k++) begin
            if (w_en[k]) r_side[k] <= r_side[k-1];
        end
    end

    etm_merge u_merge (
        .i_clk        (i_clk),
        .i_en         (w_en[STAGES-1:LANE_STAGES]),
        .i_taper_mode (r_taper_mode),
        .i_accumulate (r_accumulate),
        .i_factors    (w_factors),
        .i_side       (r_side[LANE_STAGES-1]),
        .o_out_re     (o_out_re),
        .o_out_im     (o_out_im),
        .o_weight     (o_weight),
        .o_saturated  (o_saturated)
    );

    `ETM_ASSERT(a_weight_max, i_clk, i_rst_n, o_out_valid |-> (o_weight <= ONE_Q16), "weight above one")
    `ETM_ASSERT(a_sat_needs_acc, i_clk, i_rst_n, (o_out_valid && o_saturated) |-> r_accumulate, "clip without accumulation")
    `ETM_ASSERT(a_stall_full, i_clk, i_rst_n, !o_in_ready |-> r_vld[0], "input stalled with empty first stage")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for edge_taper_mask_2d: streams grid samples under several window
// settings, predicts each weighted word in place and compares it field by field.
// Depends on etm_pkg (port widths, register indexes) and the RTL of edge_taper_mask_2d.
module testbench;
    import etm_pkg::*;

    // One grid sample as offered on the input channel.
    typedef struct {
        logic [COORD_BITS-1:0]         column;
        logic [COORD_BITS-1:0]         row;
        logic signed [SAMPLE_BITS-1:0] model_re;
        logic signed [SAMPLE_BITS-1:0] model_im;
        logic signed [SAMPLE_BITS-1:0] prior_re;
        logic signed [SAMPLE_BITS-1:0] prior_im;
    } sample_word_t;

    // One weighted word as it should leave the block.
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] out_re;
        logic signed [SAMPLE_BITS-1:0] out_im;
        logic [WEIGHT_BITS-1:0]        weight;
        logic                          saturated;
    } masked_word_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ADDR_BITS-1:0]          paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [COORD_BITS-1:0]         i_column = '0;
    logic [COORD_BITS-1:0]         i_row = '0;
    logic signed [SAMPLE_BITS-1:0] i_model_re = '0;
    logic signed [SAMPLE_BITS-1:0] i_model_im = '0;
    logic signed [SAMPLE_BITS-1:0] i_prior_re = '0;
    logic signed [SAMPLE_BITS-1:0] i_prior_im = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_out_re;
    logic signed [SAMPLE_BITS-1:0] o_out_im;
    logic [WEIGHT_BITS-1:0]        o_weight;
    logic                          o_saturated;

    edge_taper_mask_2d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_column(i_column), .i_row(i_row),
        .i_model_re(i_model_re), .i_model_im(i_model_im),
        .i_prior_re(i_prior_re), .i_prior_im(i_prior_im),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_re(o_out_re), .o_out_im(o_out_im),
        .o_weight(o_weight), .o_saturated(o_saturated)
    );

    // Shadow copy of the window registers, updated as each APB write lands.
    longint a1_size = 4096, a2_size = 4096;
    longint a1_low = 0, a1_high = 4096, a2_low = 0, a2_high = 4096;
    bit     taper_on = 1'b0, accum_on = 1'b0;

    // Taper lookup: entry k is the Q1.16 value of sin^2(pi/2 * k/1024).
    int unsigned taper_lut [TABLE_ENTRIES];

    sample_word_t samples_to_send [$];
    masked_word_t words_awaited [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_left = 0;
    int  errors = 0;
    int  cycles = 0;
    bit  in_taken = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Cosine in Q30 of an angle in [0, pi/2], from a truncated Taylor series.
    function automatic longint cos_series(longint unsigned ang);
        longint unsigned sq;
        longint unsigned term;
        longint          acc;
        sq   = (ang * ang) >> 30;
        term = 64'd1 << 30;
        acc  = 64'sd1 << 30;
        for (int n = 1; n <= 9; n++) begin
            term = ((term * sq) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) acc -= longint'(term);
            else            acc += longint'(term);
        end
        if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
        if (acc < 0) acc = 0;
        return acc;
    endfunction

    function automatic void fill_taper_lut();
        longint unsigned folded;
        longint          c;
        longint          h;
        bit              past_half;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            past_half = (2 * k > TABLE_ENTRIES);
            folded = past_half ? TABLE_ENTRIES - k : k;
            c = cos_series((64'hC90FDAA2 * folded) / TABLE_ENTRIES);
            if (past_half) c = -c;
            h = ((64'sd1 << 30) - c) / 2;
            if (h < 0) h = 0;
            if (h > (64'sd1 << 30)) h = 64'sd1 << 30;
            taper_lut[k] = int'((h + (64'sd1 << 13)) >>> 14);
        end
    endfunction

    // Factor of one edge band: zero at the edge (or when the band has no width),
    // one once the distance reaches the band length, the table in between.
    function automatic longint band_gain(longint gap, longint span);
        longint idx;
        if (span <= 0 || gap <= 0) return 0;
        if (gap >= span) return 65536;
        idx = gap * TABLE_ENTRIES / span;
        if (idx >= TABLE_ENTRIES) idx = TABLE_ENTRIES - 1;
        return taper_lut[idx];
    endfunction

    function automatic longint fold_gain(longint w, longint f);
        return (w * f + 32768) >> 16;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clip_q15(longint v, inout bit hit);
        if (v > 32767) begin
            v = 32767;
            hit = 1'b1;
        end
        if (v < -32768) begin
            v = -32768;
            hit = 1'b1;
        end
        return SAMPLE_BITS'(v);
    endfunction

    function automatic masked_word_t mask_sample(sample_word_t s);
        masked_word_t r;
        longint c, y, w, re, im;
        bit hit;
        c = s.column;
        y = s.row;
        w = 65536;
        hit = 1'b0;
        if (!taper_on) begin
            if (c < a1_low || c > a1_high || y < a2_low || y > a2_high) w = 0;
        end else begin
            if (c < a1_low)  w = fold_gain(w, band_gain(c, a1_low));
            if (c > a1_high) w = fold_gain(w, band_gain(a1_size - c, a1_size - a1_high));
            if (y < a2_low)  w = fold_gain(w, band_gain(y, a2_low));
            if (y > a2_high) w = fold_gain(w, band_gain(a2_size - y, a2_size - a2_high));
        end
        // Arithmetic shift gives the floor that Q15 rounding asks for.
        re = (longint'(s.model_re) * w + 32768) >>> 16;
        im = (longint'(s.model_im) * w + 32768) >>> 16;
        if (accum_on) begin
            re += longint'(s.prior_re);
            im += longint'(s.prior_im);
        end
        r.out_re = clip_q15(re, hit);
        r.out_im = clip_q15(im, hit);
        r.weight = WEIGHT_BITS'(w);
        r.saturated = hit;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // A register write: setup cycle, then access cycle; it lands at the edge that ends it.
    task automatic reg_write(t_reg_idx idx, int unsigned val);
        longint v;
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_BITS'({idx, 2'b00});
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        // Oversized sizes and bounds are held at the largest axis.
        v = val & 32'h1FFF;
        if (v > MAX_AXIS) v = MAX_AXIS;
        case (idx)
            REG_AXIS1_SIZE: a1_size = v;
            REG_AXIS2_SIZE: a2_size = v;
            REG_AXIS1_LOW:  a1_low = v;
            REG_AXIS1_HIGH: a1_high = v;
            REG_AXIS2_LOW:  a2_low = v;
            REG_AXIS2_HIGH: a2_high = v;
            REG_TAPER_MODE: taper_on = val[0];
            REG_ACCUMULATE: accum_on = val[0];
        endcase
    endtask

    // The block is idle once every queued sample is in and every word has come back.
    // Each sample makes exactly one word, so the extra cycles are only a margin.
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || i_in_valid || words_awaited.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic push_sample(int col, int row, int mre, int mim, int pre, int pim);
        sample_word_t s;
        s.column = COORD_BITS'(col);
        s.row = COORD_BITS'(row);
        s.model_re = SAMPLE_BITS'(mre);
        s.model_im = SAMPLE_BITS'(mim);
        s.prior_re = SAMPLE_BITS'(pre);
        s.prior_im = SAMPLE_BITS'(pim);
        samples_to_send.push_back(s);
    endtask

    // Writes one axis: mostly small grids so the bands are short and well covered,
    // sometimes the full axis, an out-of-range value, an inverted window, or a
    // high bound at or past the grid size.
    task automatic setup_axis(t_reg_idx size_reg, t_reg_idx low_reg, t_reg_idx high_reg);
        int unsigned sz, lo, hi;
        case ($urandom_range(0, 9))
            0: begin
                sz = ($urandom_range(0, 1) != 0) ? 8191 : 4096;
                lo = $urandom_range(0, 300);
                hi = ($urandom_range(0, 1) != 0) ? 8191 : 4096 - $urandom_range(0, 300);
            end
            1: begin
                sz = $urandom_range(8, 80);
                lo = $urandom_range(sz / 2, sz);
                hi = $urandom_range(0, sz / 2 - 1);
            end
            2: begin
                sz = $urandom_range(1, 60);
                lo = $urandom_range(0, sz);
                hi = sz + $urandom_range(0, 3);
            end
            default: begin
                sz = $urandom_range(2, 96);
                lo = $urandom_range(0, sz / 2);
                hi = $urandom_range(sz / 2, sz);
            end
        endcase
        reg_write(size_reg, sz);
        reg_write(low_reg, lo);
        reg_write(high_reg, hi);
    endtask

    function automatic int pick_coord(longint sz);
        longint top;
        top = sz + 6;
        if (top > 4095) top = 4095;
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 4095);
        return $urandom_range(0, int'(top));
    endfunction

    function automatic int pick_q15();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Sender: a new sample goes out at the falling edge after the last one was taken,
    // or after a gap. Valid stays up with a fixed payload until the block takes it.
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_column <= samples_to_send[0].column;
                i_row <= samples_to_send[0].row;
                i_model_re <= samples_to_send[0].model_re;
                i_model_im <= samples_to_send[0].model_im;
                i_prior_re <= samples_to_send[0].prior_re;
                i_prior_im <= samples_to_send[0].prior_im;
                i_in_valid <= 1'b1;
                void'(samples_to_send.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted down here when asked for.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: the expected word is formed when the sample is taken, under the
    // registers in force, and the oldest one is checked against each word out.
    always @(posedge i_clk) begin
        sample_word_t s;
        masked_word_t want;
        in_taken = i_in_valid && o_in_ready;
        if (in_taken) begin
            s.column = i_column;
            s.row = i_row;
            s.model_re = i_model_re;
            s.model_im = i_model_im;
            s.prior_re = i_prior_re;
            s.prior_im = i_prior_im;
            words_awaited.push_back(mask_sample(s));
        end
        if (o_out_valid && i_out_ready) begin
            if (words_awaited.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                want = words_awaited.pop_front();
                if (o_out_re !== want.out_re) report("out_re", o_out_re, want.out_re);
                if (o_out_im !== want.out_im) report("out_im", o_out_im, want.out_im);
                if (o_weight !== want.weight) report("weight", o_weight, want.weight);
                if (o_saturated !== want.saturated)
                    report("saturated", o_saturated, want.saturated);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("[edge_taper_mask_2d] ERROR");
            $finish;
        end
    end

    initial begin
        fill_taper_lut();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset window passes everything: full-scale and small samples at the grid corners.
        push_sample(0, 0, -32768, 32767, 0, 0);
        push_sample(4095, 4095, 32767, -32768, 32767, -32768);
        push_sample(4095, 0, -1, 1, 0, 0);
        push_sample(0, 4095, 0, 0, -32768, 32767);
        wait_drained();

        // A small tapered grid with accumulation: the edge itself, mid-band, the
        // exact window bounds, the far edge, past the grid, and prior values that clip.
        reg_write(REG_AXIS1_SIZE, 64);
        reg_write(REG_AXIS2_SIZE, 40);
        reg_write(REG_AXIS1_LOW, 16);
        reg_write(REG_AXIS1_HIGH, 48);
        reg_write(REG_AXIS2_LOW, 8);
        reg_write(REG_AXIS2_HIGH, 32);
        reg_write(REG_TAPER_MODE, 1);
        reg_write(REG_ACCUMULATE, 1);
        push_sample(0, 20, 32767, 32767, 0, 0);
        push_sample(8, 20, 32767, -32768, 0, 0);
        push_sample(16, 8, 20000, -20000, 100, -100);
        push_sample(48, 32, -32768, 32767, 0, 0);
        push_sample(56, 20, 32767, 32767, 0, 0);
        push_sample(64, 40, 32767, 32767, 5, 5);
        push_sample(100, 2000, 12345, -12345, 7, -7);
        push_sample(3, 3, 32767, 32767, 1, 1);
        push_sample(30, 20, 32767, -32768, 32767, -32768);
        push_sample(30, 20, -32768, 32767, -32768, 32767);
        push_sample(60, 36, -32768, -32768, -32768, -32768);
        push_sample(4095, 4095, -32768, -32768, 0, 0);
        wait_drained();

        // Same grid, hard window: in, out, and on each bound.
        reg_write(REG_TAPER_MODE, 0);
        reg_write(REG_ACCUMULATE, 0);
        push_sample(15, 20, 32767, 32767, 9, 9);
        push_sample(16, 20, 32767, -32768, 9, 9);
        push_sample(48, 33, 1000, -1000, 0, 0);
        push_sample(49, 32, 1000, -1000, 0, 0);
        wait_drained();

        // Random phases: a mostly busy sender against a slow receiver, the reverse, then
        // full rate; the last two each get one long hold-off that backs the pipeline up.
        for (int phase = 0; phase < 12; phase++) begin
            setup_axis(REG_AXIS1_SIZE, REG_AXIS1_LOW, REG_AXIS1_HIGH);
            setup_axis(REG_AXIS2_SIZE, REG_AXIS2_LOW, REG_AXIS2_HIGH);
            reg_write(REG_TAPER_MODE, (phase % 4 == 3) ? 0 : 1);
            reg_write(REG_ACCUMULATE, $urandom_range(0, 1));
            if (phase < 4) begin
                send_idle_pct = 12;
                recv_idle_pct = 58;
            end else if (phase < 8) begin
                send_idle_pct = 58;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 120; n++)
                push_sample(pick_coord(a1_size), pick_coord(a2_size),
                            pick_q15(), pick_q15(), pick_q15(), pick_q15());
            if (phase == 4 || phase == 9) begin
                @(posedge i_clk);
                hold_left = 300;
            end
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("[edge_taper_mask_2d] OK");
        end else begin
            $display("[edge_taper_mask_2d] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/etm_pkg.sv
hw/rtl/etm_lane.sv
hw/rtl/etm_merge.sv
hw/rtl/edge_taper_mask_2d.sv
tb/testbench.sv
